// ===== rtl/cog_pkg.sv =====
// ----------------------------------------------------------------------------
// cog_pkg: shared types and constants for the circle outline generator
// Opcodes, decision constants, pixel order table and queue status.
// ----------------------------------------------------------------------------
package cog_pkg;

   // default coordinate width of the held state
   localparam int COORD_BITS_DEFAULT = 16;

   // step jobs that may wait between front and back
   localparam int QUEUE_DEPTH = 2;

   // midpoint decision constants
   localparam int DEC_INIT    = 3;
   localparam int DEC_INC_NEG = 6;
   localparam int DEC_INC_POS = 10;

   // eight symmetric points per step
   localparam int PIX_PER_STEP = 8;
   localparam int IDX_BITS     = $clog2(PIX_PER_STEP);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIX_PER_STEP - 1);

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // how one symmetric point is formed from (x, y)
   typedef struct packed {
      logic swap;    // use y on the x axis and x on the y axis
      logic neg_x;
      logic neg_y;
   } sym_type;

   // point order within a step:
   // (+x,+y) (+y,+x) (-x,+y) (+y,-x) (+x,-y) (-y,+x) (-x,-y) (-y,-x)
   function automatic sym_type sym_sel(input logic [IDX_BITS-1:0] idx);
      sym_type s;
      case (idx)
         3'd0:    s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
         3'd1:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
         3'd2:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
         3'd3:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
         3'd4:    s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
         3'd5:    s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
         3'd6:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
         default: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/cog_front.sv =====
// ----------------------------------------------------------------------------
// cog_front: request decode and midpoint state
// Takes start and step beats, keeps the circle state, queues step jobs.
// ----------------------------------------------------------------------------
module cog_front #(
   parameter int COORD_BITS = cog_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic signed [15:0]           req_center_x,
   input  logic signed [15:0]           req_center_y,
   input  logic [14:0]                  req_radius,
   input  logic [31:0]                  req_color,
   input  cog_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output logic [4*COORD_BITS+32:0]     q_job
);
   import cog_pkg::*;

   localparam int DEC_W  = COORD_BITS + 4;
   localparam int WIDE_W = 48;

   logic [COORD_BITS-1:0] offset_x_ff, offset_x_in;
   logic [COORD_BITS-1:0] offset_y_ff, offset_y_in;
   logic [DEC_W-1:0]      decision_ff, decision_in;
   logic [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic [31:0]           color_ff, color_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  is_start;
   logic [WIDE_W-1:0]     radius_wide;
   logic [WIDE_W-1:0]     cx_wide;
   logic [WIDE_W-1:0]     cy_wide;
   logic [COORD_BITS-2:0] radius_cut;
   logic [DEC_W-1:0]      x_dec;
   logic [DEC_W-1:0]      y_dec;
   logic [COORD_BITS:0]   x_next;
   logic [COORD_BITS:0]   y_next;
   logic                  step_done;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~req_stall;
   assign is_start  = (opcode_type'(req_opcode) == OP_START);

   // center keeps its low bits sign extended, radius its low COORD_BITS-1 bits
   assign radius_wide = WIDE_W'(req_radius);
   assign cx_wide     = WIDE_W'(req_center_x);
   assign cy_wide     = WIDE_W'(req_center_y);
   assign radius_cut  = radius_wide[COORD_BITS-2:0];

   assign x_dec = DEC_W'(offset_x_ff);
   assign y_dec = DEC_W'(offset_y_ff);

   always_comb begin
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      color_in    = color_ff;
      active_in   = active_ff;
      q_push      = 1'b0;

      x_next = {1'b0, offset_x_ff} + (COORD_BITS+1)'(1);
      if (decision_ff[DEC_W-1]) begin
         y_next = {1'b0, offset_y_ff};
      end else begin
         y_next = {1'b0, offset_y_ff} - (COORD_BITS+1)'(1);
      end
      step_done = $signed(x_next) > $signed(y_next);

      if (accept) begin
         if (is_start) begin
            center_x_in = cx_wide[COORD_BITS-1:0];
            center_y_in = cy_wide[COORD_BITS-1:0];
            color_in    = req_color;
            offset_x_in = '0;
            offset_y_in = COORD_BITS'(radius_cut);
            decision_in = DEC_W'(DEC_INIT) - (DEC_W'(radius_cut) << 1);
            active_in   = 1'b1;
         end else if (active_ff) begin
            q_push = 1'b1;
            if (decision_ff[DEC_W-1]) begin
               decision_in = decision_ff + (x_dec << 2) + DEC_W'(DEC_INC_NEG);
            end else begin
               decision_in = decision_ff + ((x_dec - y_dec) << 2) + DEC_W'(DEC_INC_POS);
            end
            offset_x_in = x_next[COORD_BITS-1:0];
            offset_y_in = y_next[COORD_BITS-1:0];
            if (step_done) begin
               active_in = 1'b0;
            end
         end
      end
   end

   // job carries the offsets from before the update
   assign q_job = {center_x_ff, center_y_ff, offset_x_ff, offset_y_ff, color_ff, step_done};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         color_ff    <= '0;
         active_ff   <= 1'b0;
      end else begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         color_ff    <= color_in;
         active_ff   <= active_in;
      end
   end

   a_push_needs_active: assert property (@(posedge clock) disable iff (reset)
      q_push |-> active_ff && !is_start)
      else $error("step job queued with no circle in progress");

   a_active_falls_on_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(active_ff)) |-> $past(q_push && step_done))
      else $error("circle dropped without a finishing step");

endmodule

// ===== rtl/cog_queue.sv =====
// ----------------------------------------------------------------------------
// cog_queue: small job queue
// Register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module cog_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cog_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output cog_pkg::queue_status_type status
);
   import cog_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule

// ===== rtl/cog_back.sv =====
// ----------------------------------------------------------------------------
// cog_back: pixel sequencer
// Walks the eight symmetric points of the head job, one pixel per beat.
// ----------------------------------------------------------------------------
module cog_back #(
   parameter int COORD_BITS = cog_pkg::COORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cog_pkg::queue_status_type  q_status,
   input  logic [4*COORD_BITS+32:0]   q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_BITS:0] rsp_pixel_x,
   output logic signed [COORD_BITS:0] rsp_pixel_y,
   output logic [31:0]                rsp_pixel_color,
   output logic                       rsp_last_of_step,
   output logic                       rsp_circle_done
);
   import cog_pkg::*;

   logic [COORD_BITS-1:0] job_cx, job_cy, job_ox, job_oy;
   logic [31:0]           job_color;
   logic                  job_done;

   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [COORD_BITS:0]   px_ff, px_in;
   logic [COORD_BITS:0]   py_ff, py_in;
   logic [31:0]           color_ff;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;

   logic                  load;
   logic                  at_last;
   sym_type               sym;
   logic [COORD_BITS-1:0] a_off, b_off;
   logic [COORD_BITS:0]   cx_e, cy_e, a_e, b_e;

   assign {job_cx, job_cy, job_ox, job_oy, job_color, job_done} = q_job;

   assign load    = ~q_status.empty & (~valid_ff | ~rsp_stall);
   assign at_last = (idx_ff == LAST_IDX);
   assign q_pop   = load & at_last;

   always_comb begin
      sym   = sym_sel(idx_ff);
      a_off = sym.swap ? job_oy : job_ox;
      b_off = sym.swap ? job_ox : job_oy;
      cx_e  = {job_cx[COORD_BITS-1], job_cx};
      cy_e  = {job_cy[COORD_BITS-1], job_cy};
      a_e   = {1'b0, a_off};
      b_e   = {1'b0, b_off};
      px_in = sym.neg_x ? (cx_e - a_e) : (cx_e + a_e);
      py_in = sym.neg_y ? (cy_e - b_e) : (cy_e + b_e);

      last_in  = at_last;
      done_in  = at_last & job_done;
      valid_in = load | (valid_ff & rsp_stall);
      idx_in   = load ? (idx_ff + IDX_BITS'(1)) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         color_ff <= job_color;
         last_ff  <= last_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_x      = $signed(px_ff);
   assign rsp_pixel_y      = $signed(py_ff);
   assign rsp_pixel_color  = color_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("finish flagged off the last pixel of a step");

   a_mid_step_has_job: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> !q_status.empty)
      else $error("pixel index mid step with no job queued");

endmodule

// ===== rtl/circle_outline_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// circle_outline_pixel_generator: midpoint circle outline pixel source
// Start and step beats in, eight symmetric pixel writes per step out.
// ----------------------------------------------------------------------------
// A start beat (opcode 0) loads center, radius and color and produces no
// output. Each step beat (opcode 1) on a circle in progress produces eight
// pixel beats, the points (cx+-x, cy+-y) and (cx+-y, cy+-x) in a fixed order
// with duplicates kept; the eighth carries last_of_step, and on the final
// step also circle_done. Steps with no circle in progress are consumed
// silently. Rate: one pixel beat per cycle while a job is queued and
// rsp_stall is low, through the single output register of the pixel
// sequencer. The front end updates the decision value in the cycle a step
// is taken and queues the step job, so up to two steps may be taken ahead
// of the sequencer before req_stall rises. When idle, a step's job is first
// registered in the queue, then its first pixel in the output register.
// ----------------------------------------------------------------------------
module circle_outline_pixel_generator #(
   parameter int COORD_BITS = cog_pkg::COORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic signed [15:0]         req_center_x,
   input  logic signed [15:0]         req_center_y,
   input  logic [14:0]                req_radius,
   input  logic [31:0]                req_color,
   // pixel channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_BITS:0] rsp_pixel_x,
   output logic signed [COORD_BITS:0] rsp_pixel_y,
   output logic [31:0]                rsp_pixel_color,
   output logic                       rsp_last_of_step,
   output logic                       rsp_circle_done
);
   import cog_pkg::*;

   // job: center x, center y, offset x, offset y, color, finishing flag
   localparam int JOB_W = 4 * COORD_BITS + 33;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   logic [JOB_W-1:0] q_in_job;
   logic [JOB_W-1:0] q_head_job;

   // front: decode, circle state, decision update
   cog_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_color    (req_color),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_job        (q_in_job)
   );

   // decouples the step rate of the front from the pixel rate of the back
   cog_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_job),
      .pop       (q_pop),
      .head_data (q_head_job),
      .status    (q_status)
   );

   // back: eight symmetric points per job into the output register
   cog_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_job            (q_head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   // a step popped from the queue always ends on a last-of-step beat
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid && rsp_last_of_step)
      else $error("job retired without a last-of-step pixel");

endmodule
